>>> hw/rtl/rrps_pkg.sv
package rrps_pkg;

  // operation codes of an input word
  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_SET    = 3'd2;
  localparam logic [2:0] OP_SCHED  = 3'd3;
  localparam logic [2:0] OP_QUERY  = 3'd4;

  // process state codes that the scheduler acts on
  localparam logic [2:0] PST_RUNNING = 3'd0;
  localparam logic [2:0] PST_READY   = 3'd1;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_FULL      = 2'd1,
    STS_NOT_FOUND = 2'd2,
    STS_NO_READY  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_ADD_SCAN,
    S_ADD_LINK_NEW,
    S_ADD_LINK_CUR,
    S_RM_HEAD,
    S_RM_WALK,
    S_SET_WALK,
    S_SC_HEAD,
    S_PK_READ,
    S_PK_WALK,
    S_FIN_READ,
    S_FIN
  } ctrl_state_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_ACCEPT,
    CMD_SCAN_NEXT,
    CMD_ADD_WRITE,
    CMD_LINK_NEW,
    CMD_LINK_CUR,
    CMD_RM_SINGLE,
    CMD_WALK_FIRST,
    CMD_WALK_STEP,
    CMD_UNLINK,
    CMD_SET_STATE,
    CMD_SCHED_PREP,
    CMD_READ_S,
    CMD_MARK_RUNNING,
    CMD_OUT_LOAD
  } dp_step_t;

  typedef struct packed {
    dp_step_t step;
    logic     set_status;
    status_t  status;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       nonempty;
    logic       full;
    logic       slot_free;
    logic       self_loop;
    logic       pid_match;
    logic       pid_zero;
    logic       walk_done;
    logic       slot_ready;
    logic       is_cur;
    logic       out_free;
  } dp_flags_t;

endpackage

>>> hw/rtl/round_robin_process_scheduler.sv
// Round-robin process scheduler over a ring of MAX_SLOTS process slots. Each
// input word carries an op (add, remove, set state, schedule, query), a pid
// and a state; each word yields exactly one result word with the current
// slot's pid (0 when the ring is empty), a ring-not-empty flag and a status
// (ok, table full, pid not found or refused, no ready slot). One word is in
// work at a time. A query, a full-table add and any op refused on an empty
// ring go straight to the result; add first scans up from slot 0 for the
// lowest free slot and, on a nonempty ring, links it in after the current
// slot; set-state, schedule and remove walk the ring, where a walk reads one
// ring slot per cycle and stops once it has covered every occupied slot.
// Removing the current slot makes its successor current and starts a
// second walk, the ready search, there. Walks run through the slot RAMs,
// whose single registered read port fetches one slot's pid, state and link
// each cycle. A finished result sits in an output register, so the next word
// is taken while it waits to be drained.
// Slot pid, state and link stores are not cleared at reset; only data read
// from slots on the ring is ever used, and those have been written.
module round_robin_process_scheduler #(
  parameter int MAX_SLOTS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  // input words
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_op,
  input  logic [7:0] in_pid,
  input  logic [2:0] in_new_state,
  // result words
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_current_pid,
  output logic       out_has_current,
  output logic [1:0] out_status
);

  rrps_pkg::dp_cmd_t   cmd;
  rrps_pkg::dp_flags_t flags;

  // sequencer: decodes the op and steps through the ring walks
  rrps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .flags    (flags),
    .cmd      (cmd)
  );

  // ring registers, slot RAMs and the result register
  rrps_dp #(.MAX_SLOTS(MAX_SLOTS)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .flags           (flags),
    .in_op           (in_op),
    .in_pid          (in_pid),
    .in_new_state    (in_new_state),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_current_pid (out_current_pid),
    .out_has_current (out_has_current),
    .out_status      (out_status)
  );

  // an accepted word must be latched by the datapath in the same cycle
  a_accept_latch : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> (cmd.step == rrps_pkg::CMD_ACCEPT))
    else $error("input word accepted without latch command");

  // a result is never loaded over one that is still waiting
  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step == rrps_pkg::CMD_OUT_LOAD) |-> flags.out_free)
    else $error("result loaded while previous result pending");

  // a full table is never empty
  a_full_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == rrps_pkg::STS_FULL)) |-> out_has_current)
    else $error("table full reported on an empty ring");

  // a freshly loaded result for an empty ring shows pid 0
  a_empty_pid : assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step == rrps_pkg::CMD_OUT_LOAD) |=> (out_has_current || (out_current_pid == 8'd0)))
    else $error("empty ring reports a nonzero pid");

endmodule

>>> hw/rtl/rrps_ram.sv
module rrps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/rrps_ctrl.sv
module rrps_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rrps_pkg::dp_flags_t flags,
  output rrps_pkg::dp_cmd_t   cmd
);

  rrps_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rrps_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != rrps_pkg::S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    cmd.step       = rrps_pkg::CMD_NONE;
    cmd.set_status = 1'b0;
    cmd.status     = rrps_pkg::STS_OK;
    case (state_r)
      rrps_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.step  = rrps_pkg::CMD_ACCEPT;
          state_nxt = rrps_pkg::S_DISPATCH;
        end
      end
      rrps_pkg::S_DISPATCH: begin
        state_nxt = rrps_pkg::S_FIN_READ;
        case (flags.op)
          rrps_pkg::OP_ADD: begin
            if (flags.full) begin
              cmd.set_status = 1'b1;
              cmd.status     = rrps_pkg::STS_FULL;
            end else begin
              state_nxt = rrps_pkg::S_ADD_SCAN;
            end
          end
          rrps_pkg::OP_REMOVE: begin
            if (!flags.nonempty) begin
              cmd.set_status = 1'b1;
              cmd.status     = rrps_pkg::STS_NOT_FOUND;
            end else begin
              state_nxt = rrps_pkg::S_RM_HEAD;
            end
          end
          rrps_pkg::OP_SET: begin
            if (!flags.nonempty) begin
              cmd.set_status = 1'b1;
              cmd.status     = rrps_pkg::STS_NOT_FOUND;
            end else begin
              state_nxt = rrps_pkg::S_SET_WALK;
            end
          end
          rrps_pkg::OP_SCHED: begin
            if (!flags.nonempty) begin
              cmd.set_status = 1'b1;
              cmd.status     = rrps_pkg::STS_NO_READY;
            end else begin
              state_nxt = rrps_pkg::S_SC_HEAD;
            end
          end
          default: begin
            state_nxt = rrps_pkg::S_FIN_READ;
          end
        endcase
      end
      rrps_pkg::S_ADD_SCAN: begin
        if (flags.slot_free) begin
          cmd.step  = rrps_pkg::CMD_ADD_WRITE;
          state_nxt = flags.nonempty ? rrps_pkg::S_ADD_LINK_NEW : rrps_pkg::S_FIN_READ;
        end else begin
          cmd.step = rrps_pkg::CMD_SCAN_NEXT;
        end
      end
      rrps_pkg::S_ADD_LINK_NEW: begin
        cmd.step  = rrps_pkg::CMD_LINK_NEW;
        state_nxt = rrps_pkg::S_ADD_LINK_CUR;
      end
      rrps_pkg::S_ADD_LINK_CUR: begin
        cmd.step  = rrps_pkg::CMD_LINK_CUR;
        state_nxt = rrps_pkg::S_FIN_READ;
      end
      rrps_pkg::S_RM_HEAD: begin
        if (flags.self_loop) begin
          state_nxt = rrps_pkg::S_FIN_READ;
          if (flags.pid_match && !flags.pid_zero) begin
            cmd.step = rrps_pkg::CMD_RM_SINGLE;
          end else begin
            cmd.set_status = 1'b1;
            cmd.status     = rrps_pkg::STS_NOT_FOUND;
          end
        end else begin
          cmd.step  = rrps_pkg::CMD_WALK_FIRST;
          state_nxt = rrps_pkg::S_RM_WALK;
        end
      end
      rrps_pkg::S_RM_WALK: begin
        if (flags.walk_done) begin
          cmd.set_status = 1'b1;
          cmd.status     = rrps_pkg::STS_NOT_FOUND;
          state_nxt      = rrps_pkg::S_FIN_READ;
        end else if (flags.pid_match) begin
          cmd.step  = rrps_pkg::CMD_UNLINK;
          state_nxt = flags.is_cur ? rrps_pkg::S_PK_READ : rrps_pkg::S_FIN_READ;
        end else begin
          cmd.step = rrps_pkg::CMD_WALK_STEP;
        end
      end
      rrps_pkg::S_SET_WALK: begin
        if (flags.walk_done) begin
          cmd.set_status = 1'b1;
          cmd.status     = rrps_pkg::STS_NOT_FOUND;
          state_nxt      = rrps_pkg::S_FIN_READ;
        end else if (flags.pid_match) begin
          cmd.step  = rrps_pkg::CMD_SET_STATE;
          state_nxt = rrps_pkg::S_FIN_READ;
        end else begin
          cmd.step = rrps_pkg::CMD_WALK_STEP;
        end
      end
      rrps_pkg::S_SC_HEAD: begin
        cmd.step  = rrps_pkg::CMD_SCHED_PREP;
        state_nxt = rrps_pkg::S_PK_READ;
      end
      rrps_pkg::S_PK_READ: begin
        cmd.step  = rrps_pkg::CMD_READ_S;
        state_nxt = rrps_pkg::S_PK_WALK;
      end
      rrps_pkg::S_PK_WALK: begin
        if (flags.walk_done) begin
          cmd.set_status = 1'b1;
          cmd.status     = rrps_pkg::STS_NO_READY;
          state_nxt      = rrps_pkg::S_FIN_READ;
        end else if (flags.slot_ready) begin
          cmd.step  = rrps_pkg::CMD_MARK_RUNNING;
          state_nxt = rrps_pkg::S_FIN_READ;
        end else begin
          cmd.step = rrps_pkg::CMD_WALK_STEP;
        end
      end
      rrps_pkg::S_FIN_READ: begin
        // slot RAMs fetch the current slot's pid
        state_nxt = rrps_pkg::S_FIN;
      end
      rrps_pkg::S_FIN: begin
        if (flags.out_free) begin
          cmd.step  = rrps_pkg::CMD_OUT_LOAD;
          state_nxt = rrps_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = rrps_pkg::S_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/rrps_dp.sv
module rrps_dp #(
  parameter int MAX_SLOTS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rrps_pkg::dp_cmd_t   cmd,
  output rrps_pkg::dp_flags_t flags,
  input  logic [2:0]          in_op,
  input  logic [7:0]          in_pid,
  input  logic [2:0]          in_new_state,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [7:0]          out_current_pid,
  output logic                out_has_current,
  output logic [1:0]          out_status
);

  localparam int IDX_W = $clog2(MAX_SLOTS);
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);

  // latched word
  logic [2:0] op_r, op_nxt;
  logic [7:0] pid_r, pid_nxt;
  logic [2:0] nst_r, nst_nxt;

  // ring control
  logic [IDX_W-1:0]     cur_r, cur_nxt;
  logic                 nonempty_r, nonempty_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [MAX_SLOTS-1:0] in_use_r, in_use_nxt;

  // walk and scan
  logic [IDX_W-1:0] s_r, s_nxt;
  logic [IDX_W-1:0] prev_r, prev_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  rrps_pkg::status_t status_r, status_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_pid_r, out_pid_nxt;
  logic              out_has_r, out_has_nxt;
  rrps_pkg::status_t out_status_r, out_status_nxt;

  // slot RAMs
  logic [IDX_W-1:0] raddr;
  logic [7:0]       rd_pid;
  logic [2:0]       rd_state;
  logic [IDX_W-1:0] rd_link;
  logic             pid_we, st_we, ln_we;
  logic [IDX_W-1:0] st_waddr, ln_waddr;
  logic [2:0]       st_wdata;
  logic [IDX_W-1:0] ln_wdata;

  rrps_ram #(.WIDTH(8), .DEPTH(MAX_SLOTS)) u_pid_ram (
    .clk   (clk),
    .we    (pid_we),
    .waddr (idx_r),
    .wdata (pid_r),
    .raddr (raddr),
    .rdata (rd_pid)
  );

  rrps_ram #(.WIDTH(3), .DEPTH(MAX_SLOTS)) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (raddr),
    .rdata (rd_state)
  );

  rrps_ram #(.WIDTH(IDX_W), .DEPTH(MAX_SLOTS)) u_link_ram (
    .clk   (clk),
    .we    (ln_we),
    .waddr (ln_waddr),
    .wdata (ln_wdata),
    .raddr (raddr),
    .rdata (rd_link)
  );

  always_comb begin
    op_nxt         = op_r;
    pid_nxt        = pid_r;
    nst_nxt        = nst_r;
    cur_nxt        = cur_r;
    nonempty_nxt   = nonempty_r;
    count_nxt      = count_r;
    in_use_nxt     = in_use_r;
    s_nxt          = s_r;
    prev_nxt       = prev_r;
    n_nxt          = n_r;
    idx_nxt        = idx_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_pid_nxt    = out_pid_r;
    out_has_nxt    = out_has_r;
    out_status_nxt = out_status_r;
    raddr          = cur_r;
    pid_we         = 1'b0;
    st_we          = 1'b0;
    ln_we          = 1'b0;
    st_waddr       = s_r;
    st_wdata       = nst_r;
    ln_waddr       = idx_r;
    ln_wdata       = rd_link;
    case (cmd.step)
      rrps_pkg::CMD_ACCEPT: begin
        op_nxt     = in_op;
        pid_nxt    = in_pid;
        nst_nxt    = in_new_state;
        status_nxt = rrps_pkg::STS_OK;
        s_nxt      = cur_r;
        n_nxt      = '0;
        idx_nxt    = '0;
      end
      rrps_pkg::CMD_SCAN_NEXT: begin
        idx_nxt = idx_r + 1'b1;
      end
      rrps_pkg::CMD_ADD_WRITE: begin
        pid_we             = 1'b1;
        st_we              = 1'b1;
        st_waddr           = idx_r;
        in_use_nxt[idx_r]  = 1'b1;
        count_nxt          = count_r + 1'b1;
        if (!nonempty_r) begin
          // first slot: points at itself
          cur_nxt      = idx_r;
          ln_we        = 1'b1;
          ln_wdata     = idx_r;
          nonempty_nxt = 1'b1;
        end
      end
      rrps_pkg::CMD_LINK_NEW: begin
        ln_we = 1'b1;
      end
      rrps_pkg::CMD_LINK_CUR: begin
        ln_we    = 1'b1;
        ln_waddr = cur_r;
        ln_wdata = idx_r;
      end
      rrps_pkg::CMD_RM_SINGLE: begin
        in_use_nxt[cur_r] = 1'b0;
        nonempty_nxt      = 1'b0;
        cur_nxt           = '0;
        count_nxt         = '0;
      end
      rrps_pkg::CMD_WALK_FIRST: begin
        prev_nxt = cur_r;
        s_nxt    = rd_link;
        n_nxt    = '0;
        raddr    = rd_link;
      end
      rrps_pkg::CMD_WALK_STEP: begin
        prev_nxt = s_r;
        s_nxt    = rd_link;
        n_nxt    = n_r + 1'b1;
        raddr    = rd_link;
      end
      rrps_pkg::CMD_UNLINK: begin
        ln_we           = 1'b1;
        ln_waddr        = prev_r;
        in_use_nxt[s_r] = 1'b0;
        count_nxt       = count_r - 1'b1;
        if (s_r == cur_r) begin
          // successor becomes current, then a ready search starts there
          cur_nxt = rd_link;
          s_nxt   = rd_link;
          n_nxt   = '0;
        end
      end
      rrps_pkg::CMD_SET_STATE: begin
        st_we = 1'b1;
      end
      rrps_pkg::CMD_SCHED_PREP: begin
        if (rd_state == rrps_pkg::PST_RUNNING) begin
          st_we    = 1'b1;
          st_waddr = cur_r;
          st_wdata = rrps_pkg::PST_READY;
        end
        s_nxt = rd_link;
        n_nxt = '0;
      end
      rrps_pkg::CMD_READ_S: begin
        raddr = s_r;
      end
      rrps_pkg::CMD_MARK_RUNNING: begin
        st_we    = 1'b1;
        st_wdata = rrps_pkg::PST_RUNNING;
        cur_nxt  = s_r;
      end
      rrps_pkg::CMD_OUT_LOAD: begin
        out_valid_nxt  = 1'b1;
        out_pid_nxt    = nonempty_r ? rd_pid : 8'd0;
        out_has_nxt    = nonempty_r;
        out_status_nxt = status_r;
      end
      default: begin
        raddr = cur_r;
      end
    endcase
    if (cmd.set_status) begin
      status_nxt = cmd.status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= '0;
      nonempty_r  <= 1'b0;
      count_r     <= '0;
      in_use_r    <= '0;
      n_r         <= '0;
      idx_r       <= '0;
      status_r    <= rrps_pkg::STS_OK;
      out_valid_r <= 1'b0;
    end else begin
      cur_r       <= cur_nxt;
      nonempty_r  <= nonempty_nxt;
      count_r     <= count_nxt;
      in_use_r    <= in_use_nxt;
      n_r         <= n_nxt;
      idx_r       <= idx_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    pid_r        <= pid_nxt;
    nst_r        <= nst_nxt;
    s_r          <= s_nxt;
    prev_r       <= prev_nxt;
    out_pid_r    <= out_pid_nxt;
    out_has_r    <= out_has_nxt;
    out_status_r <= out_status_nxt;
  end

  always_comb begin
    flags.op         = op_r;
    flags.nonempty   = nonempty_r;
    flags.full       = (count_r == CNT_W'(MAX_SLOTS));
    flags.slot_free  = !in_use_r[idx_r];
    flags.self_loop  = (rd_link == cur_r);
    flags.pid_match  = (rd_pid == pid_r);
    flags.pid_zero   = (pid_r == 8'd0);
    flags.walk_done  = (n_r >= count_r);
    flags.slot_ready = (rd_state == rrps_pkg::PST_READY);
    flags.is_cur     = (s_r == cur_r);
    flags.out_free   = !out_valid_r || !out_stall;
  end

  assign out_valid       = out_valid_r;
  assign out_current_pid = out_pid_r;
  assign out_has_current = out_has_r;
  assign out_status      = out_status_r;

endmodule
